[rtl/ufmw_pkg.sv]
package ufmw_pkg;

    localparam int NUM_VTX = 1024;
    localparam int VTX_W   = $clog2(NUM_VTX);
    localparam int SIZE_W  = VTX_W + 1;
    localparam int WT_W    = 30;
    localparam int SUM_W   = WT_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [WT_W-1:0] MIN_EMPTY = {WT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;

    localparam logic [VTX_W-1:0] SOURCE_RST = VTX_W'(1);
    localparam logic [VTX_W-1:0] TARGET_RST = VTX_W'(NUM_VTX - 1);

    // walk slots: edge endpoints first, watched pair second
    localparam logic [1:0] WALK_U   = 2'd0;
    localparam logic [1:0] WALK_V   = 2'd1;
    localparam logic [1:0] WALK_SRC = 2'd2;
    localparam logic [1:0] WALK_TGT = 2'd3;

    typedef struct packed {
        logic [VTX_W-1:0]  parent;
        logic [SIZE_W-1:0] size;
        logic [WT_W-1:0]   minw;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_JOIN_LINK,
        ST_JOIN_ROOT,
        ST_EVAL,
        ST_DONE
    } state_t;

endpackage

[rtl/ufmw_if.sv]
interface ufmw_edge_if import ufmw_pkg::*;
(
);
    logic             valid;
    logic             ready;
    logic [VTX_W-1:0] vertex_u;
    logic [VTX_W-1:0] vertex_v;
    logic [WT_W-1:0]  edge_weight;

    modport source (output valid, vertex_u, vertex_v, edge_weight, input ready);
    modport sink   (input valid, vertex_u, vertex_v, edge_weight, output ready);
endinterface

interface ufmw_result_if import ufmw_pkg::*;
(
);
    logic             valid;
    logic             ready;
    logic             endpoints_joined;
    logic             answer_valid;
    logic [SUM_W-1:0] best_sum;

    modport source (output valid, endpoints_joined, answer_valid, best_sum, input ready);
    modport sink   (input valid, endpoints_joined, answer_valid, best_sum, output ready);
endinterface

interface ufmw_cfg_if import ufmw_pkg::*;
(
);
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VTX_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/union_find_with_component_min_weight_unit.sv]
// Per edge: root walks from u and v, a join write (two when the edge merges two sets),
//   then root walks from source and target and the result; chain depth is at most 10.
// One edge at a time: the next is taken only once the result is loaded; the root walks
//   go one entry per cycle through the single read port of the vertex memory.
// Reset: rst_n clears control at once, then a clearing pass initializes the whole
//   vertex memory; edges are held off until it ends, configuration writes are taken.
module union_find_with_component_min_weight_unit import ufmw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ufmw_edge_if.sink     edges,
    ufmw_result_if.source results,
    ufmw_cfg_if.sink      cfg
);

    // Vertex store: parent link, set size and component minimum in one entry.
    entry_t mem [NUM_VTX];
    entry_t rdata_reg;

    logic             mem_we;
    logic [VTX_W-1:0] mem_wa;
    entry_t           mem_wd;
    logic [VTX_W-1:0] mem_ra;

    state_t state_reg, state_next;

    logic [VTX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0]       walk_reg, walk_next;
    logic [VTX_W-1:0] cur_reg, cur_next;

    // watched pair
    logic [VTX_W-1:0] source_reg, target_reg;

    // captured edge
    logic [VTX_W-1:0] u_reg, v_reg;
    logic [WT_W-1:0]  w_reg;

    // walk results
    logic [VTX_W-1:0] ru_reg, rv_reg, rs_reg, rt_reg;
    entry_t           eu_reg, ev_reg, es_reg;
    logic             root_hit;

    // running best
    logic             best_seen_reg, best_seen_next;
    logic [SUM_W-1:0] best_reg, best_next;
    logic             joined_reg, joined_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic             out_joined_reg;
    logic             out_ans_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic             out_load;

    // join helpers
    logic             same_root;
    logic             swap;
    logic [VTX_W-1:0] big_root, small_root;
    entry_t           big_e, small_e;
    logic [WT_W-1:0]  min_pair, min_all, min_same;
    logic [SUM_W-1:0] cand;

    logic [VTX_W-1:0] next_start;

    // ---------------------------------------------------------------------
    // Memory: one write port, one registered read port.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[mem_ra];
    end

    // ---------------------------------------------------------------------
    // Configuration: always ready, writes beyond the list are dropped.
    // ---------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg <= SOURCE_RST;
            target_reg <= TARGET_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SOURCE: source_reg <= cfg.data;
                CFG_TARGET: target_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Join arithmetic on the two captured roots.
    // ---------------------------------------------------------------------
    always_comb
    begin
        same_root  = (ru_reg == rv_reg);
        // the smaller set goes under the larger; on a tie the root of v moves
        swap       = (eu_reg.size < ev_reg.size);
        big_root   = swap ? rv_reg : ru_reg;
        small_root = swap ? ru_reg : rv_reg;
        big_e      = swap ? ev_reg : eu_reg;
        small_e    = swap ? eu_reg : ev_reg;
        min_pair   = (eu_reg.minw < ev_reg.minw) ? eu_reg.minw : ev_reg.minw;
        min_all    = (min_pair < w_reg) ? min_pair : w_reg;
        min_same   = (eu_reg.minw < w_reg) ? eu_reg.minw : w_reg;
        cand       = {1'b0, es_reg.minw} + {1'b0, w_reg};
    end

    // start vertex of the walk that follows the current one
    always_comb
    begin
        case (walk_reg)
            WALK_U:   next_start = v_reg;
            WALK_V:   next_start = source_reg;
            WALK_SRC: next_start = target_reg;
            default:  next_start = u_reg;
        endcase
    end

    assign root_hit = (rdata_reg.parent == cur_reg);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            walk_reg      <= WALK_U;
            cur_reg       <= '0;
            best_seen_reg <= 1'b0;
            best_reg      <= '0;
            joined_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            walk_reg      <= walk_next;
            cur_reg       <= cur_next;
            best_seen_reg <= best_seen_next;
            best_reg      <= best_next;
            joined_reg    <= joined_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        walk_next      = walk_reg;
        cur_next       = cur_reg;
        best_seen_next = best_seen_reg;
        best_next      = best_reg;
        joined_next    = joined_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_wa         = cur_reg;
        mem_wd         = rdata_reg;
        mem_ra         = cur_reg;
        edges.ready    = 1'b0;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // initialize one entry a cycle: own parent, size one, no edge yet
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
                mem_wd = '{parent: clr_cnt_reg, size: SIZE_W'(1), minw: MIN_EMPTY};
                clr_cnt_next = clr_cnt_reg + VTX_W'(1);
                if (clr_cnt_reg == VTX_W'(NUM_VTX - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                edges.ready = 1'b1;
                if (edges.valid)
                begin
                    walk_next  = WALK_U;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                // issue the first read of a walk
                mem_ra     = (walk_reg == WALK_U) ? u_reg : source_reg;
                cur_next   = mem_ra;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (root_hit)
                begin
                    if (walk_reg == WALK_V)
                    begin
                        state_next = ST_JOIN_LINK;
                    end
                    else if (walk_reg == WALK_TGT)
                    begin
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        // chain straight into the next walk of the pair
                        mem_ra    = next_start;
                        cur_next  = next_start;
                        walk_next = walk_reg + 2'd1;
                    end
                end
                else
                begin
                    // advance one link up the chain
                    mem_ra   = rdata_reg.parent;
                    cur_next = rdata_reg.parent;
                end
            end
            ST_JOIN_LINK:
            begin
                mem_we = 1'b1;
                if (same_root)
                begin
                    // edge inside one component: lower its minimum
                    mem_wa     = ru_reg;
                    mem_wd     = '{parent: ru_reg, size: eu_reg.size, minw: min_same};
                    walk_next  = WALK_SRC;
                    state_next = ST_START;
                end
                else
                begin
                    // hang the smaller root under the larger one
                    mem_wa     = small_root;
                    mem_wd     = '{parent: big_root, size: small_e.size, minw: small_e.minw};
                    state_next = ST_JOIN_ROOT;
                end
            end
            ST_JOIN_ROOT:
            begin
                mem_we     = 1'b1;
                mem_wa     = big_root;
                mem_wd     = '{parent: big_root, size: big_e.size + small_e.size,
                               minw: min_all};
                walk_next  = WALK_SRC;
                state_next = ST_START;
            end
            ST_EVAL:
            begin
                joined_next = (rs_reg == rt_reg);
                if ((rs_reg == rt_reg) && (!best_seen_reg || (cand < best_reg)))
                begin
                    best_next      = cand;
                    best_seen_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && edges.valid)
        begin
            u_reg <= edges.vertex_u;
            v_reg <= edges.vertex_v;
            w_reg <= edges.edge_weight;
        end
        if (state_reg == ST_WALK && root_hit)
        begin
            case (walk_reg)
                WALK_U:
                begin
                    ru_reg <= cur_reg;
                    eu_reg <= rdata_reg;
                end
                WALK_V:
                begin
                    rv_reg <= cur_reg;
                    ev_reg <= rdata_reg;
                end
                WALK_SRC:
                begin
                    rs_reg <= cur_reg;
                    es_reg <= rdata_reg;
                end
                default:
                begin
                    rt_reg <= cur_reg;
                end
            endcase
        end
        if (out_load)
        begin
            out_joined_reg <= joined_reg;
            out_ans_reg    <= best_seen_reg;
            out_sum_reg    <= best_seen_reg ? best_reg : '0;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.endpoints_joined = out_joined_reg;
    assign results.answer_valid     = out_ans_reg;
    assign results.best_sum         = out_sum_reg;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import ufmw_pkg::*;

    // Generous wall-clock ceiling at a 2 ns clock, several times the slowest run.
    localparam int WATCHDOG_NS  = 1_500_000;
    localparam int TAIL_CYCLES  = 64;
    localparam int DRAIN_LIMIT  = 20_000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_EDGES  = 220;

    localparam logic [WT_W-1:0] MAX_LEGAL_WT = 30'h3FFF_FFFE;

    // Receiver stall patterns.
    typedef enum int {
        RX_STEADY,
        RX_LIGHT,
        RX_HALF,
        RX_HEAVY
    } rx_mode_t;

    // One result of the unit, as predicted.
    typedef struct packed {
        logic             joined;
        logic             ans_valid;
        logic [SUM_W-1:0] sum;
    } edge_outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    ufmw_edge_if   edge_ch ();
    ufmw_result_if res_ch ();
    ufmw_cfg_if    cfg_ch ();

    union_find_with_component_min_weight_unit uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .edges   (edge_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    // Predicted disjoint-set store and watch registers.
    logic [VTX_W-1:0]  dsu_parent [NUM_VTX];
    logic [SIZE_W-1:0] dsu_size   [NUM_VTX];
    logic [WT_W-1:0]   dsu_minw   [NUM_VTX];
    logic [SUM_W-1:0]  best_total_q;
    logic              best_seen_q;
    logic [VTX_W-1:0]  watch_src;
    logic [VTX_W-1:0]  watch_tgt;

    edge_outcome_t pending_outcomes [$];
    int            fail_count  = 0;
    int            result_seq  = 0;
    int            burst_left  = 0;
    bit            gaps_on     = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #(WATCHDOG_NS);
        $display("Test completed with failures");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH t=%0t: %s", $time, what);
        fail_count++;
    endtask

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic void reset_store();
        for (int i = 0; i < NUM_VTX; i++)
        begin
            dsu_parent[i] = VTX_W'(i);
            dsu_size[i]   = SIZE_W'(1);
            dsu_minw[i]   = MIN_EMPTY;
        end
        best_total_q = '0;
        best_seen_q  = 1'b0;
        watch_src    = SOURCE_RST;
        watch_tgt    = TARGET_RST;
    endfunction

    // Walk to the root, then point every vertex on the path straight at it.
    function automatic logic [VTX_W-1:0] find_root(input logic [VTX_W-1:0] start);
        logic [VTX_W-1:0] root;
        logic [VTX_W-1:0] cur;
        logic [VTX_W-1:0] nxt;
        root = start;
        while (dsu_parent[root] != root)
            root = dsu_parent[root];
        cur = start;
        while (cur != root)
        begin
            nxt = dsu_parent[cur];
            dsu_parent[cur] = root;
            cur = nxt;
        end
        return root;
    endfunction

    function automatic logic [WT_W-1:0] min_wt(input logic [WT_W-1:0] a,
                                               input logic [WT_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // Merge one edge into the store and work out the result it produces.
    function automatic edge_outcome_t apply_edge(input logic [VTX_W-1:0] u,
                                                 input logic [VTX_W-1:0] v,
                                                 input logic [WT_W-1:0]  w);
        logic [VTX_W-1:0] ru;
        logic [VTX_W-1:0] rv;
        logic [VTX_W-1:0] swap;
        logic [VTX_W-1:0] rs;
        logic [VTX_W-1:0] rt;
        logic [SUM_W-1:0] cand;
        edge_outcome_t    outc;
        ru = find_root(u);
        rv = find_root(v);
        if (ru == rv)
            dsu_minw[ru] = min_wt(dsu_minw[ru], w);
        else
        begin
            // smaller set goes under the larger; on a tie v's root goes under u's
            if (dsu_size[ru] < dsu_size[rv])
            begin
                swap = ru;
                ru   = rv;
                rv   = swap;
            end
            dsu_parent[rv] = ru;
            dsu_size[ru]   = dsu_size[ru] + dsu_size[rv];
            dsu_minw[ru]   = min_wt(min_wt(dsu_minw[ru], dsu_minw[rv]), w);
        end
        outc.joined = 1'b0;
        rs = find_root(watch_src);
        rt = find_root(watch_tgt);
        if (rs == rt)
        begin
            // an empty minimum is added as is
            cand = SUM_W'(dsu_minw[rs]) + SUM_W'(w);
            outc.joined = 1'b1;
            if (!best_seen_q || cand < best_total_q)
            begin
                best_total_q = cand;
                best_seen_q  = 1'b1;
            end
        end
        outc.ans_valid = best_seen_q;
        outc.sum       = best_seen_q ? best_total_q : '0;
        return outc;
    endfunction

    // ---------------------------------------------------------------
    // Result side: stall on a pattern of its own, check each transaction
    // ---------------------------------------------------------------

    initial
    begin : result_stalls
        rx_mode_t mode;
        int       run_len;
        res_ch.ready = 1'b0;
        forever
        begin
            mode    = rx_mode_t'($urandom_range(0, 3));
            run_len = $urandom_range(4, 40);
            repeat (run_len)
            begin
                @(negedge clk);
                case (mode)
                    RX_STEADY: res_ch.ready <= 1'b1;
                    RX_LIGHT:  res_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:   res_ch.ready <= ($urandom_range(0, 1) != 0);
                    default:   res_ch.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // Compare each accepted result against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        edge_outcome_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
                flag_mismatch($sformatf("result %0d arrived with no edge outstanding",
                                        result_seq));
            else
            begin
                want = pending_outcomes.pop_front();
                if (res_ch.endpoints_joined !== want.joined)
                    flag_mismatch($sformatf("result %0d endpoints_joined got %b want %b",
                                            result_seq, res_ch.endpoints_joined,
                                            want.joined));
                if (res_ch.answer_valid !== want.ans_valid)
                    flag_mismatch($sformatf("result %0d answer_valid got %b want %b",
                                            result_seq, res_ch.answer_valid,
                                            want.ans_valid));
                if (res_ch.best_sum !== want.sum)
                    flag_mismatch($sformatf("result %0d best_sum got 0x%0h want 0x%0h",
                                            result_seq, res_ch.best_sum, want.sum));
            end
            result_seq++;
        end
    end

    // ---------------------------------------------------------------
    // Edge and configuration drivers (entered and left at a falling edge)
    // ---------------------------------------------------------------

    // Send one edge; valid is left high so a back-to-back edge keeps it asserted.
    task automatic send_edge(input logic [VTX_W-1:0] u,
                             input logic [VTX_W-1:0] v,
                             input logic [WT_W-1:0]  w);
        int            gap;
        edge_outcome_t outc;
        if (burst_left == 0)
        begin
            // start a new burst, optionally after an idle gap
            gap        = gaps_on ? $urandom_range(1, 12) : 0;
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                edge_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        edge_ch.valid       <= 1'b1;
        edge_ch.vertex_u    <= u;
        edge_ch.vertex_v    <= v;
        edge_ch.edge_weight <= w;
        @(posedge clk);
        while (edge_ch.ready !== 1'b1)
            @(posedge clk);
        outc = apply_edge(u, v, w);
        pending_outcomes.insert(pending_outcomes.size(), outc);
        @(negedge clk);
    endtask

    // Drop edge valid and hold until every predicted result has come back.
    task automatic wait_drained();
        edge_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VTX_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            CFG_SOURCE: watch_src = data;
            CFG_TARGET: watch_tgt = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Reprogram the watched pair once the unit is idle.
    task automatic set_watch(input logic [VTX_W-1:0] src, input logic [VTX_W-1:0] tgt);
        wait_drained();
        cfg_write(CFG_SOURCE, src);
        cfg_write(CFG_TARGET, tgt);
        cfg_ch.valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset watch pair (1, 1023): unjoined start, empty-minimum union, zero weight.
    task automatic test_default_watch();
        send_edge(10'd5, 10'd6, 30'd100);               // not joined, no answer yet
        send_edge(10'd1, 10'd1023, MIN_EMPTY);          // all-ones weight joins the pair
        send_edge(10'd1023, 10'd1, 30'h3800_0000);      // inside component lowers min
        send_edge(10'd0, 10'd1022, 30'd0);              // zero weight, unwatched component
        send_edge(10'd1022, 10'd0, MAX_LEGAL_WT);       // min stays zero
    endtask

    // Watch register extremes, source equal to target, all-ones self loop.
    task automatic test_watch_extremes();
        set_watch(10'd0, 10'd1023);
        send_edge(10'd2, 10'd3, 30'd5);                 // answer held, pair apart
        set_watch(10'd512, 10'd512);
        send_edge(10'd7, 10'd8, 30'h3A00_0000);         // joined on empty minimum
        send_edge(10'd512, 10'd512, MIN_EMPTY);         // all ones never lowers empty
        send_edge(10'd512, 10'd513, 30'h3000_0000);     // tie union, best holds
        set_watch(10'd1023, 10'd0);
        send_edge(10'd1023, 10'd0, 30'h3800_0000);      // merge with zero-min component
    endtask

    // Weights arriving out of increasing order still follow the same rules.
    task automatic test_unsorted_edges();
        set_watch(10'd600, 10'd601);
        send_edge(10'd600, 10'd601, 30'h1800_0000);
        send_edge(10'd601, 10'd600, 30'h1000_0000);
        send_edge(10'd602, 10'd603, 30'h1200_0000);
        send_edge(10'd603, 10'd600, 30'h0FFF_FFFF);
    endtask

    // Phases of well-formed edge streams on a vertex window that holds the watched
    // pair after phase 0, weight bands stepping down per phase, mixed with random noise edges.
    task automatic test_random_edges();
        int               phase;
        int               k;
        int               span;
        int               base;
        logic [VTX_W-1:0] s;
        logic [VTX_W-1:0] t;
        logic [VTX_W-1:0] u;
        logic [VTX_W-1:0] v;
        logic [WT_W-1:0]  w;
        logic [WT_W-1:0]  run_w;
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            base = $urandom_range(0, NUM_VTX - 1);
            case (phase % 4)
                0:       span = 8;
                1:       span = 32;
                2:       span = 128;
                default: span = NUM_VTX;
            endcase
            if (phase == 0)
            begin
                s = VTX_W'(NUM_VTX - 1);
                t = '0;
            end
            else if (phase == 3)
            begin
                s = VTX_W'(base);
                t = s;
            end
            else
            begin
                s = VTX_W'(base + $urandom_range(0, span - 1));
                t = VTX_W'(base + $urandom_range(0, span - 1));
            end
            set_watch(s, t);
            // every third phase runs the sender without gaps
            gaps_on = (phase % 3 != 1);
            run_w   = WT_W'((RAND_PHASES - phase) << 24) + WT_W'($urandom_range(0, 1 << 20));
            for (k = 0; k < PHASE_EDGES; k++)
            begin
                // hold the sender mid-stream until the unit has drained
                if (phase == 2 && k == PHASE_EDGES / 2)
                    wait_drained();
                if ($urandom_range(0, 99) < 85)
                begin
                    u     = VTX_W'(base + $urandom_range(0, span - 1));
                    v     = VTX_W'(base + $urandom_range(0, span - 1));
                    run_w = run_w + WT_W'($urandom_range(0, 64));
                    w     = run_w;
                end
                else
                begin
                    u = VTX_W'($urandom);
                    v = VTX_W'($urandom);
                    w = WT_W'($urandom);
                end
                send_edge(u, v, w);
            end
        end
    endtask

    // Drain, let the pipeline settle, then report.
    task automatic finish_run();
        int spins;
        wait_drained_bounded:
        begin
            edge_ch.valid <= 1'b0;
            spins = 0;
            while (pending_outcomes.size() != 0 && spins < DRAIN_LIMIT)
            begin
                @(negedge clk);
                spins++;
            end
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_outcomes.size() != 0)
            flag_mismatch($sformatf("%0d predicted results never arrived",
                                    pending_outcomes.size()));
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n               = 1'b0;
        edge_ch.valid       = 1'b0;
        edge_ch.vertex_u    = '0;
        edge_ch.vertex_v    = '0;
        edge_ch.edge_weight = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_SOURCE;
        cfg_ch.data         = '0;
        reset_store();
        // assert reset from time zero, release it on a falling edge
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_watch();
        test_watch_extremes();
        test_unsorted_edges();
        test_random_edges();
        finish_run();
    end

endmodule
